// File: hw/rtl/shsort_pkg.sv
// Shared constants, types and state encoding for the Shell sort block.
`timescale 1ns / 1ps
`default_nettype none

package shsort_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_HOLD_RD,
        ST_HOLD_LAT,
        ST_PROBE,
        ST_PLACE,
        ST_EMIT
    } state_t;

    // Control that goes with one value pushed into the output register.
    typedef struct packed {
        logic push;
        logic last;
        logic overflow;
    } emit_t;

endpackage : shsort_pkg

`default_nettype wire

// File: hw/rtl/shsort_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module shsort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : shsort_ram

`default_nettype wire

// File: hw/rtl/shsort_engine.sv
// Sequencer that loads the store, runs the gapped insertion passes and reads results out.
`timescale 1ns / 1ps
`default_nettype none

module shsort_engine
    import shsort_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [DATA_W-1:0] in_value,
    input  wire logic              in_last,
    // memory port
    output logic                   mem_we,
    output logic [ADDR_W-1:0]      mem_waddr,
    output logic [DATA_W-1:0]      mem_wdata,
    output logic                   mem_re,
    output logic [ADDR_W-1:0]      mem_raddr,
    input  wire logic [DATA_W-1:0] mem_rdata,
    // output stage
    input  wire logic              slot_free,
    output emit_t                  emit
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [CNT_W-1:0]   gap_reg, gap_next;
    logic [CNT_W-1:0]   i_reg, i_next;      // pass index; read index while emitting
    logic [CNT_W-1:0]   pos_reg, pos_next;  // hole position; load index while emitting
    logic [DATA_W-1:0]  held_reg, held_next;
    logic               pend_reg, pend_next;

    logic               accept;
    logic [CNT_W-1:0]   count_inc;
    logic [CNT_W-1:0]   i_inc;
    logic [CNT_W-1:0]   gap_half;
    logic [CNT_W-1:0]   pos_dn;
    logic               move;
    logic               load;
    logic               issue;
    logic               out_last;

    assign accept    = in_valid && !in_stall;
    assign count_inc = count_reg + CNT_W'(1);
    assign i_inc     = i_reg + CNT_W'(1);
    assign gap_half  = gap_reg >> 1;
    assign pos_dn    = pos_reg - gap_reg;
    assign move      = held_reg < mem_rdata;
    assign load      = pend_reg && slot_free;
    assign issue     = (i_reg < count_reg) && (!pend_reg || load);
    assign out_last  = pos_reg == count_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gap_reg  <= gap_next;
        i_reg    <= i_next;
        pos_reg  <= pos_next;
        held_reg <= held_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        gap_next   = gap_reg;
        i_next     = i_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        pend_next  = pend_reg;
        in_stall   = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = pos_reg[ADDR_W-1:0];
        mem_wdata  = held_reg;
        mem_re     = 1'b0;
        mem_raddr  = i_reg[ADDR_W-1:0];
        emit       = '{push: 1'b0, last: out_last, overflow: ovf_reg};

        unique case (state_reg)
            ST_LOAD:
            begin
                in_stall  = 1'b0;
                mem_waddr = count_reg[ADDR_W-1:0];
                mem_wdata = in_value;
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_inc;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        // first gap is half the final count
                        gap_next = ((count_reg < CNT_W'(MAX_ITEMS)) ? count_inc
                                                                    : count_reg) >> 1;
                        i_next   = gap_next;
                        pos_next = '0;
                        pend_next = 1'b0;
                        if (gap_next == '0)
                        begin
                            i_next     = '0;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_HOLD_RD;
                        end
                    end
                end
            end

            ST_HOLD_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_HOLD_LAT;
            end

            ST_HOLD_LAT:
            begin
                held_next  = mem_rdata;
                pos_next   = i_reg;
                mem_re     = 1'b1;
                mem_raddr  = ADDR_W'(i_reg - gap_reg);
                state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                mem_we = 1'b1;
                if (move)
                begin
                    // shift the larger neighbor up into the hole
                    mem_wdata = mem_rdata;
                    pos_next  = pos_dn;
                    if (pos_dn >= gap_reg)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ADDR_W'(pos_dn - gap_reg);
                        state_next = ST_PROBE;
                    end
                    else
                    begin
                        state_next = ST_PLACE;
                    end
                end
            end

            ST_PLACE:
            begin
                mem_we = 1'b1;
            end

            ST_EMIT:
            begin
                mem_re     = issue;
                emit.push  = load;
                i_next     = issue ? i_inc : i_reg;
                pos_next   = load ? pos_reg + CNT_W'(1) : pos_reg;
                pend_next  = issue ? 1'b1 : (load ? 1'b0 : pend_reg);
                if (load && out_last)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_LOAD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // Advance to the next element of the pass, or to the next gap, once the
        // held value is written back.
        if ((state_reg == ST_PLACE) || ((state_reg == ST_PROBE) && !move))
        begin
            if (i_inc < count_reg)
            begin
                i_next     = i_inc;
                state_next = ST_HOLD_RD;
            end
            else if (gap_half == '0)
            begin
                i_next     = '0;
                pos_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_EMIT;
            end
            else
            begin
                gap_next   = gap_half;
                i_next     = gap_half;
                state_next = ST_HOLD_RD;
            end
        end
    end

endmodule : shsort_engine

`default_nettype wire

// File: hw/rtl/shsort_out_stage.sv
// Output register that holds one result item until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module shsort_out_stage
    import shsort_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire emit_t             emit,
    input  wire logic [DATA_W-1:0] emit_value,
    output logic                   slot_free,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DATA_W-1:0]      sorted_value,
    output logic                   last_result,
    output logic                   overflow
);

    logic              valid_reg;
    logic [DATA_W-1:0] value_reg;
    logic              last_reg;
    logic              ovf_reg;

    assign slot_free = !valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit.push)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.push)
        begin
            value_reg <= emit_value;
            last_reg  <= emit.last;
            ovf_reg   <= emit.overflow;
        end
    end

    assign out_valid    = valid_reg;
    assign sorted_value = value_reg;
    assign last_result  = last_reg;
    assign overflow     = ovf_reg;

endmodule : shsort_out_stage

`default_nettype wire

// File: hw/rtl/shell_sort_halving_gaps.sv
// Top level of the Shell sort block: store, sequencer and output register.
`timescale 1ns / 1ps
`default_nettype none

// Collects unsigned 32-bit values, one per input item, into a 32-entry store
// until an item marked last_item arrives, then sorts them ascending by Shell
// sort (gaps n/2, n/4, ... 1, one gapped insertion pass per gap) and sends
// them out in order, last_result set on the final one. Values arriving when
// the store is full are dropped, and overflow is set on every result of that
// batch. Loading accepts one item per cycle. Once the last item is taken,
// in_stall stays high while sorting and reading out: every element of a pass
// first fetches the held value, then compares it with one neighbor per step
// (a compare that moves an entry also writes it back), and takes a further
// step when the held value lands at the bottom of its chain. The single read
// port of the store sets that pace. Results then leave at one per cycle while
// out_stall is low, from the registered read port, and the block takes the
// next batch as soon as the final result sits in the output register.
module shell_sort_halving_gaps
    import shsort_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [DATA_W-1:0] value,
    input  wire logic              last_item,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [DATA_W-1:0]      sorted_value,
    output logic                   last_result,
    output logic                   overflow
);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              slot_free;
    emit_t             emit;

    // Element store; every read and write of the sort goes through here.
    shsort_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Load, sort and read-out sequencer.
    shsort_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_value  (value),
        .in_last   (last_item),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .slot_free (slot_free),
        .emit      (emit)
    );

    // Hold each result item until the receiver takes it; read data from the
    // store feeds it directly.
    shsort_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .emit         (emit),
        .emit_value   (mem_rdata),
        .slot_free    (slot_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sorted_value (sorted_value),
        .last_result  (last_result),
        .overflow     (overflow)
    );

endmodule : shell_sort_halving_gaps

`default_nettype wire

// File: hw/rtl/shsort_checker.sv
// Port-level checks of the Shell sort block and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none

module shsort_checker
    import shsort_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic [DATA_W-1:0] value,
    input wire logic              last_item,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [DATA_W-1:0] sorted_value,
    input wire logic              last_result,
    input wire logic              overflow
);

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sorted_value)
            && $stable(last_result) && $stable(overflow))
        else $error("stalled result item changed");

    // The end of a batch closes the input until its results are out.
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_item |=> in_stall)
        else $error("input open right after last item");

    // No new batch is taken while a result other than the final one waits at the output.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_result |-> in_stall)
        else $error("input open during read-out");

    // Overflow is one flag for the whole batch.
    a_ovf_batch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_result |=> !out_valid || overflow == $past(overflow))
        else $error("overflow changed within a batch");

endmodule : shsort_checker

bind shell_sort_halving_gaps shsort_checker u_checker (.*);

`default_nettype wire
